### rtl/core/bfqs_pkg.sv
// ----------------------------------------------------------------------------
// bfqs_pkg
// Shared types and fixed port widths of the bounded queue with search.
// ----------------------------------------------------------------------------
`default_nettype none

package bfqs_pkg;

   // Fixed widths of the command, result and capacity fields.
   localparam int CMD_W       = 2;
   localparam int VALUE_PORT_W = 32;
   localparam int COUNT_PORT_W = 5;
   localparam int POS_PORT_W   = 4;
   localparam int CAP_W        = 5;

   // Capacity register value after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_CLEAR  = 2'd3
   } bfqs_cmd_type;

endpackage : bfqs_pkg

`default_nettype wire

### rtl/core/bounded_fifo_queue_with_search.sv
// ----------------------------------------------------------------------------
// bounded_fifo_queue_with_search
// Bounded FIFO of signed values held in a circular buffer in one synchronous
// RAM, with push, pop of the oldest entry, search for a value, and clear.
// ----------------------------------------------------------------------------
// Push, clear and any refused command answer in the cycle after the command
// transfer; a pop with two or more entries reads the new head from the RAM and
// answers from ST_POP; a search over N entries scans them in ST_SEARCH, one RAM
// read per entry. busy holds off the next command during ST_POP and ST_SEARCH;
// other commands can follow every cycle. The result strobe cannot be stalled.
// Synchronous reset empties the queue, capacity 16.
`default_nettype none

module bounded_fifo_queue_with_search #(
   parameter int MAX_DEPTH   = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // Command channel
   input  wire                                    start,
   output logic                                   busy,
   input  wire  [bfqs_pkg::CMD_W-1:0]             req_command,
   input  wire  signed [bfqs_pkg::VALUE_PORT_W-1:0] req_value,
   // Result channel
   output logic                                   rsp_valid,
   output logic                                   rsp_success,
   output logic [bfqs_pkg::COUNT_PORT_W-1:0]      rsp_entry_count,
   output logic signed [bfqs_pkg::VALUE_PORT_W-1:0] rsp_head_value,
   output logic signed [bfqs_pkg::VALUE_PORT_W-1:0] rsp_tail_value,
   output logic                                   rsp_ends_valid,
   output logic                                   rsp_is_full,
   output logic                                   rsp_is_empty,
   output logic                                   rsp_match_found,
   output logic [bfqs_pkg::POS_PORT_W-1:0]        rsp_match_position,
   // Capacity register write channel
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [bfqs_pkg::CAP_W-1:0]             csr_wdata
);

   import bfqs_pkg::*;

   localparam int IDX_W  = $clog2(MAX_DEPTH);
   localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
   localparam int SUM_W  = IDX_W + 1;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int POS_W  = (IDX_W > POS_PORT_W) ? IDX_W : POS_PORT_W;
   localparam int EXT_W  = (VALUE_WIDTH > VALUE_PORT_W) ? VALUE_WIDTH : VALUE_PORT_W;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_DEPTH - 1);
   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(MAX_DEPTH);
   localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(MAX_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SEARCH
   } state_type;

   // Advance a circular buffer index with wrap at the depth.
   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] a);
      return (a == LAST_IDX) ? '0 : a + IDX_W'(1);
   endfunction

   // Stored word to result port width, zero-extended or truncated.
   function automatic logic signed [VALUE_PORT_W-1:0] to_port(
      input logic [VALUE_WIDTH-1:0] v);
      logic [EXT_W-1:0] t;
      t = EXT_W'(v);
      return t[VALUE_PORT_W-1:0];
   endfunction

   // Entry storage and its registered read port.
   logic [VALUE_WIDTH-1:0] mem [MAX_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;

   // Control and data registers.
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [VALUE_WIDTH-1:0] head_val_ff, head_val_in;
   logic [VALUE_WIDTH-1:0] tail_val_ff, tail_val_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [IDX_W-1:0]       addr_ff, addr_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic [CAP_W-1:0]       cap_ff;

   // Registered result fields.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_success_ff, rsp_success_in;
   logic [COUNT_PORT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic signed [VALUE_PORT_W-1:0] rsp_head_ff, rsp_head_in;
   logic signed [VALUE_PORT_W-1:0] rsp_tail_ff, rsp_tail_in;
   logic                          rsp_ends_ff, rsp_ends_in;
   logic                          rsp_full_ff, rsp_full_in;
   logic                          rsp_empty_ff, rsp_empty_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [POS_PORT_W-1:0]         rsp_pos_ff, rsp_pos_in;

   // Helper values.
   logic                   accept;
   bfqs_cmd_type           cmd;
   logic signed [EXT_W-1:0] req_ext;
   logic [VALUE_WIDTH-1:0] req_key;
   logic [SUM_W-1:0]       tail_sum;
   logic [IDX_W-1:0]       tail_addr;
   logic [CMP_W-1:0]       count_cmp;
   logic [CMP_W-1:0]       count_next_cmp;
   logic [CMP_W-1:0]       cap_cmp;
   logic [POS_W-1:0]       pos_ext;
   logic                   emit;
   logic                   ok;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign cmd       = bfqs_cmd_type'(req_command);
   assign csr_ready = 1'b1;

   // Bring the command value to the stored width with sign extension.
   assign req_ext = EXT_W'(req_value);
   assign req_key = req_ext[VALUE_WIDTH-1:0];

   // Write slot just past the newest entry.
   assign tail_sum  = {1'b0, head_ff} + SUM_W'(count_ff);
   assign tail_addr = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                              : tail_sum[IDX_W-1:0];

   assign count_cmp = CMP_W'(count_ff);
   assign cap_cmp   = CMP_W'(cap_ff);

   // Command sequencing and next-state logic.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      head_val_in = head_val_ff;
      tail_val_in = tail_val_ff;
      key_in      = key_ff;
      addr_in     = addr_ff;
      cmp_idx_in  = cmp_idx_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      rd_addr     = next_idx(addr_ff);
      wr_en       = 1'b0;
      wr_addr     = tail_addr;
      wr_data     = req_key;
      emit        = 1'b0;
      ok          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            found_in = 1'b0;
            pos_in   = '0;
            if (accept) begin
               case (cmd)
                  CMD_PUSH: begin
                     emit = 1'b1;
                     if ((count_cmp < cap_cmp) && (count_cmp < DEPTH_CMP)) begin
                        ok          = 1'b1;
                        wr_en       = 1'b1;
                        count_in    = count_ff + CNT_W'(1);
                        tail_val_in = req_key;
                        if (count_ff == '0) begin
                           head_val_in = req_key;
                        end
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        emit = 1'b1;
                     end else if (count_ff == CNT_W'(1)) begin
                        emit     = 1'b1;
                        ok       = 1'b1;
                        count_in = '0;
                        head_in  = next_idx(head_ff);
                     end else begin
                        // Fetch the entry that becomes the new head.
                        rd_addr  = next_idx(head_ff);
                        state_in = ST_POP;
                     end
                  end
                  CMD_SEARCH: begin
                     if (count_ff == '0) begin
                        emit = 1'b1;
                     end else begin
                        // Start the scan at the head entry.
                        rd_addr    = head_ff;
                        addr_in    = head_ff;
                        cmp_idx_in = '0;
                        key_in     = req_key;
                        state_in   = ST_SEARCH;
                     end
                  end
                  CMD_CLEAR: begin
                     emit     = 1'b1;
                     ok       = 1'b1;
                     count_in = '0;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            emit        = 1'b1;
            ok          = 1'b1;
            head_val_in = rd_data_ff;
            head_in     = next_idx(head_ff);
            count_in    = count_ff - CNT_W'(1);
            state_in    = ST_IDLE;
         end
         ST_SEARCH: begin
            // Later matches overwrite earlier ones, so the last one is kept.
            if (rd_data_ff == key_ff) begin
               found_in = 1'b1;
               pos_in   = cmp_idx_ff;
            end
            if (CNT_W'(cmp_idx_ff) + CNT_W'(1) == count_ff) begin
               emit     = 1'b1;
               ok       = found_in;
               state_in = ST_IDLE;
            end else begin
               addr_in    = next_idx(addr_ff);
               cmp_idx_in = cmp_idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Result fields reflect the queue after the command.
      count_next_cmp = CMP_W'(count_in);
      pos_ext        = POS_W'(pos_in);
      rsp_valid_in   = emit;
      rsp_success_in = ok;
      rsp_count_in   = count_next_cmp[COUNT_PORT_W-1:0];
      rsp_ends_in    = (count_in != '0);
      rsp_empty_in   = (count_in == '0);
      rsp_full_in    = (count_next_cmp >= cap_cmp) || (count_next_cmp >= DEPTH_CMP);
      rsp_head_in    = rsp_ends_in ? to_port(head_val_in) : '0;
      rsp_tail_in    = rsp_ends_in ? to_port(tail_val_in) : '0;
      rsp_found_in   = found_in;
      rsp_pos_in     = found_in ? pos_ext[POS_PORT_W-1:0] : '0;
   end

   // Entry RAM: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Sequencer state, queue bookkeeping and registered results.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         cap_ff       <= CAP_RESET;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_wdata;
         end
      end
      head_val_ff    <= head_val_in;
      tail_val_ff    <= tail_val_in;
      key_ff         <= key_in;
      addr_ff        <= addr_in;
      cmp_idx_ff     <= cmp_idx_in;
      pos_ff         <= pos_in;
      rsp_success_ff <= rsp_success_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_head_ff    <= rsp_head_in;
      rsp_tail_ff    <= rsp_tail_in;
      rsp_ends_ff    <= rsp_ends_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_pos_ff     <= rsp_pos_in;
   end

   // Result ports.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_success        = rsp_success_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_head_value     = rsp_head_ff;
   assign rsp_tail_value     = rsp_tail_ff;
   assign rsp_ends_valid     = rsp_ends_ff;
   assign rsp_is_full        = rsp_full_ff;
   assign rsp_is_empty       = rsp_empty_ff;
   assign rsp_match_found    = rsp_found_ff;
   assign rsp_match_position = rsp_pos_ff;

endmodule : bounded_fifo_queue_with_search

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded queue with search. A bit-true software
// copy of the queue predicts the status of every accepted command, and each
// strobed status is checked field by field against the oldest prediction.
// Directed commands cover the value extremes, every command and the refusal
// cases. Random phases follow, each under its own capacity setting.
// ----------------------------------------------------------------------------

module tb;
   import bfqs_pkg::*;

   localparam int QUEUE_DEPTH     = 16;
   localparam int IDLE_LIMIT      = 5000;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 108;
   localparam int POOL_SIZE       = 6;
   localparam int DRAIN_CYCLES    = 20;

   typedef struct {
      bfqs_cmd_type                    command;
      logic signed [VALUE_PORT_W-1:0] value;
   } queue_cmd_type;

   typedef struct {
      logic                            success;
      logic [COUNT_PORT_W-1:0]         entry_count;
      logic signed [VALUE_PORT_W-1:0]  head_value;
      logic signed [VALUE_PORT_W-1:0]  tail_value;
      logic                            ends_valid;
      logic                            is_full;
      logic                            is_empty;
      logic                            match_found;
      logic [POS_PORT_W-1:0]           match_position;
   } queue_status_type;

   // Clock, reset and block inputs, all known from time zero.
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic [CMD_W-1:0]                req_command = CMD_PUSH;
   logic signed [VALUE_PORT_W-1:0]  req_value = '0;
   logic                            csr_valid = 1'b0;
   logic [CAP_W-1:0]                csr_wdata = '0;

   logic                            busy;
   logic                            rsp_valid;
   logic                            rsp_success;
   logic [COUNT_PORT_W-1:0]         rsp_entry_count;
   logic signed [VALUE_PORT_W-1:0]  rsp_head_value;
   logic signed [VALUE_PORT_W-1:0]  rsp_tail_value;
   logic                            rsp_ends_valid;
   logic                            rsp_is_full;
   logic                            rsp_is_empty;
   logic                            rsp_match_found;
   logic [POS_PORT_W-1:0]           rsp_match_position;
   logic                            csr_ready;

   // Predicted queue contents and capacity register.
   logic signed [VALUE_PORT_W-1:0]  model_entries [QUEUE_DEPTH];
   int unsigned                     model_count = 0;
   logic [CAP_W-1:0]                model_capacity = CAP_RESET;

   queue_cmd_type                   pending_commands [$];
   queue_status_type                expected_status [$];
   logic signed [VALUE_PORT_W-1:0]  value_pool [POOL_SIZE];

   logic                            cmd_xfer = 1'b0;
   bit                              gaps_enabled = 1'b1;
   int                              burst_left = 1;
   int                              gap_left = 0;
   int                              idle_cycles = 0;
   int                              error_count = 0;

   bounded_fifo_queue_with_search dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_success        (rsp_success),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_head_value     (rsp_head_value),
      .rsp_tail_value     (rsp_tail_value),
      .rsp_ends_valid     (rsp_ends_valid),
      .rsp_is_full        (rsp_is_full),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_match_found    (rsp_match_found),
      .rsp_match_position (rsp_match_position),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one command to the predicted queue and returns the status it
   // should produce. Capacities above the depth behave as the full depth.
   function automatic queue_status_type apply_command(input queue_cmd_type item);
      queue_status_type st;
      int unsigned      limit;
      st = '{default: '0};
      limit = (model_capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : model_capacity;
      case (item.command)
         CMD_PUSH: begin
            if (model_count < limit) begin
               model_entries[model_count] = item.value;
               model_count++;
               st.success = 1'b1;
            end
         end
         CMD_POP: begin
            if (model_count > 0) begin
               for (int i = 1; i < model_count; i++)
                  model_entries[i-1] = model_entries[i];
               model_count--;
               st.success = 1'b1;
            end
         end
         CMD_SEARCH: begin
            // The last match wins, so keep scanning toward the tail.
            for (int i = 0; i < model_count; i++) begin
               if (model_entries[i] == item.value) begin
                  st.match_found    = 1'b1;
                  st.match_position = POS_PORT_W'(i);
               end
            end
            st.success = st.match_found;
         end
         default: begin
            model_count = 0;
            st.success  = 1'b1;
         end
      endcase
      st.entry_count = COUNT_PORT_W'(model_count);
      if (model_count > 0) begin
         st.head_value = model_entries[0];
         st.tail_value = model_entries[model_count-1];
         st.ends_valid = 1'b1;
      end
      st.is_full  = (model_count >= limit);
      st.is_empty = (model_count == 0);
      return st;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   task automatic compare_status(input queue_status_type want);
      check_field("success", 32'(want.success), 32'(rsp_success));
      check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
      check_field("head_value", want.head_value, rsp_head_value);
      check_field("tail_value", want.tail_value, rsp_tail_value);
      check_field("ends_valid", 32'(want.ends_valid), 32'(rsp_ends_valid));
      check_field("is_full", 32'(want.is_full), 32'(rsp_is_full));
      check_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
      check_field("match_found", 32'(want.match_found), 32'(rsp_match_found));
      check_field("match_position", 32'(want.match_position),
                  32'(rsp_match_position));
   endtask

   // Monitor: checks each strobed status, predicts each command transfer and
   // tracks capacity writes.
   always @(posedge clock) begin : monitor
      queue_cmd_type sampled;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_status.size() == 0) begin
               error_count++;
               $display("%0t: status strobed with no command outstanding", $time);
            end else begin
               compare_status(expected_status.pop_front());
            end
         end
         if (start && !busy) begin
            sampled.command = bfqs_cmd_type'(req_command);
            sampled.value   = req_value;
            expected_status.push_back(apply_command(sampled));
         end
         if (csr_valid && csr_ready)
            model_capacity = csr_wdata;
      end
      cmd_xfer <= !reset && start && !busy;
   end

   // Driver: presents pending commands in bursts, separated by random gaps while gaps_enabled is set.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (cmd_xfer)
            void'(pending_commands.pop_front());
         if (start && !cmd_xfer) begin
            // Command still waiting for the block to go idle; hold it.
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
         end else if (pending_commands.size() > 0) begin
            start       <= 1'b1;
            req_command <= pending_commands[0].command;
            req_value   <= pending_commands[0].value;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = gaps_enabled ? $urandom_range(1, 6) : 0;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any command or capacity transfer.
   always @(posedge clock) begin
      if ((start && !busy) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic add_command(input bfqs_cmd_type command,
                              input logic signed [VALUE_PORT_W-1:0] value);
      queue_cmd_type item;
      item.command = command;
      item.value   = value;
      pending_commands.push_back(item);
   endtask

   // Waits until every command has been transferred and answered.
   task automatic drain_queue();
      while (pending_commands.size() != 0 || expected_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] capacity);
      @(negedge clock);
      csr_wdata <= capacity;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Half or more of the values come from a small pool so searches hit and duplicates occur.
   function automatic logic signed [VALUE_PORT_W-1:0] pick_value(input int pool_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < pool_pct)
         return value_pool[$urandom_range(0, POOL_SIZE-1)];
      if (r < pool_pct + 8) begin
         case ($urandom_range(0, 3))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic add_random_commands(input int count, input int push_pct);
      int           r;
      bfqs_cmd_type command;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 3)
            command = CMD_CLEAR;
         else if (r < 28)
            command = CMD_SEARCH;
         else
            command = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
         add_command(command, pick_value(command == CMD_SEARCH ? 75 : 50));
      end
   endtask

   initial begin
      logic [CAP_W-1:0] capacity_plan [RANDOM_PHASES];

      capacity_plan =
         '{5'd31, 5'd1, 5'd16, 5'd0, 5'd7, 5'd2, 5'd16, 5'd12, 5'd4, 5'd24, 5'd16, 5'd9};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, duplicates, last-match search, clear, then refused pop
      // and search on an empty queue, at the reset capacity.
      add_command(CMD_PUSH, 32'sh7fff_ffff);
      add_command(CMD_PUSH, 32'sh8000_0000);
      add_command(CMD_PUSH, 32'sh0);
      add_command(CMD_PUSH, -32'sd1);
      add_command(CMD_PUSH, 32'sd5);
      add_command(CMD_PUSH, 32'sd5);
      add_command(CMD_SEARCH, -32'sd1);
      add_command(CMD_SEARCH, 32'sd5);
      add_command(CMD_SEARCH, 32'sd12345);
      add_command(CMD_POP, 32'sh0);
      add_command(CMD_POP, 32'sh0);
      add_command(CMD_SEARCH, 32'sh8000_0000);
      add_command(CMD_SEARCH, 32'sh0);
      add_command(CMD_CLEAR, 32'sh0);
      add_command(CMD_POP, 32'sh0);
      add_command(CMD_SEARCH, 32'sh0);
      add_command(CMD_PUSH, 32'sd1);
      add_command(CMD_PUSH, 32'sd2);
      add_command(CMD_PUSH, 32'sd3);
      drain_queue();

      // Capacity lowered below the held count: entries stay, pushes refused.
      write_capacity(5'd2);
      add_command(CMD_PUSH, 32'sd4);
      add_command(CMD_SEARCH, 32'sd3);
      add_command(CMD_POP, 32'sh0);
      add_command(CMD_PUSH, 32'sd9);
      add_command(CMD_POP, 32'sh0);
      add_command(CMD_PUSH, 32'sd9);
      drain_queue();

      // Zero capacity: every push refused and the queue reads full.
      write_capacity(5'd0);
      add_command(CMD_CLEAR, 32'sh0);
      add_command(CMD_PUSH, 32'sd7);
      drain_queue();

      // Random phases, each under its own capacity; the count carries over
      // between phases so some start above the new capacity.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_capacity(capacity_plan[phase]);
         for (int k = 0; k < POOL_SIZE; k++)
            value_pool[k] = $urandom;
         gaps_enabled = (phase % 3 != 1);
         add_random_commands(ITEMS_PER_PHASE, $urandom_range(30, 75));
         drain_queue();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
